@@ hw/rtl/hdtg_pkg.sv @@
// package for the hashed dither threshold generator: constants, types, helper functions
package hdtg_pkg;

    localparam logic [31:0] K_MIX_A = 32'h7feb352d;
    localparam logic [31:0] K_MIX_B = 32'h846ca68b;
    localparam logic [31:0] K_PERM  = 32'he95e1dd5;
    localparam logic [31:0] K_GOLD  = 32'h9e3779b9;
    localparam logic [31:0] K_CHAN  = 32'h85ebca6b;
    localparam logic [31:0] K_DEPTH = 32'hc2b2ae35;
    localparam logic [31:0] K_COORD = 32'h243f6a88;
    localparam logic [31:0] K_KEYX  = 32'ha511e9b3;
    localparam logic [31:0] K_KEYY  = 32'h63d83595;
    localparam logic [31:0] K_RANK  = 32'hb7e15162;
    localparam logic [31:0] K_JITX  = 32'h6a09e667;
    localparam logic [31:0] K_JITY  = 32'hbb67ae85;
    localparam logic [31:0] K_OFFX  = 32'h68bc21eb;
    localparam logic [31:0] K_OFFY  = 32'h02e5be93;

    localparam logic [16:0] SCALE_MUL = 17'd65551;
    localparam logic [11:0] SCALE_RND = 12'd2055;

    localparam logic CFG_FRAME_SEQ  = 1'b0;
    localparam logic CFG_CHAN_COUNT = 1'b1;

    typedef struct packed {
        logic       vld;
        logic [5:0] px;
        logic [5:0] py;
        logic [7:0] chw;
    } t_chan_item;

    typedef struct packed {
        logic        vld;
        logic [5:0]  px;
        logic [5:0]  py;
        logic [31:0] seed;
        logic [5:0]  offx;
        logic [5:0]  offy;
    } t_seed_item;

    function automatic logic [31:0] xs16(input logic [31:0] v);
        return v ^ (v >> 16);
    endfunction

    function automatic logic [31:0] xs15(input logic [31:0] v);
        return v ^ (v >> 15);
    endfunction

    // one restoring step of the channel wrap
    function automatic logic [7:0] mod_step(input logic [7:0] rem, input logic b,
                                            input logic [7:0] cnt);
        logic [8:0] t;
        t = {rem, b};
        if (t >= {1'b0, cnt}) begin
            t = t - {1'b0, cnt};
        end
        return t[7:0];
    endfunction

    function automatic logic [5:0] perm6_head(input logic [5:0] v, input logic [5:0] key);
        return (v ^ key) * K_PERM[5:0];
    endfunction

    function automatic logic [5:0] perm6_tail(input logic [5:0] v, input logic [5:0] khi);
        logic [5:0] t;
        t = v ^ (v >> 3);
        t = t ^ (t >> 5);
        t = t ^ khi;
        return t * K_MIX_A[5:0];
    endfunction

    function automatic logic [11:0] perm12_head(input logic [11:0] v, input logic [11:0] key);
        return (v ^ key) * K_PERM[11:0];
    endfunction

    function automatic logic [11:0] perm12_tail(input logic [11:0] v,
                                                input logic [11:0] khi);
        logic [11:0] t;
        t = v ^ (v >> 3);
        t = t ^ (t >> 5);
        t = t ^ khi;
        return t * K_MIX_A[11:0];
    endfunction

    function automatic logic [11:0] spread6(input logic [5:0] v);
        logic [11:0] r;
        r = '0;
        for (int i = 0; i < 6; i++) begin
            r[2*i] = v[i];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/hdtg_chan_wrap.sv @@
// two-stage channel wrap: channel index modulo channel count, restoring steps
module hdtg_chan_wrap (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  logic [5:0]            i_px,
    input  logic [5:0]            i_py,
    input  logic [7:0]            i_ch,
    input  logic [7:0]            i_cnt,
    output hdtg_pkg::t_chan_item  o_item
);

    logic       r_vld1;
    logic [7:0] r_rem1;
    logic [3:0] r_chlo1;
    logic [5:0] r_px1;
    logic [5:0] r_py1;
    logic       r_vld2;
    logic [5:0] r_px2;
    logic [5:0] r_py2;
    logic [7:0] r_chw2;
    logic [7:0] n_rem1;
    logic [7:0] n_rem2;

    // upper four bits
    always_comb begin
        n_rem1 = '0;
        for (int i = 7; i >= 4; i--) begin
            n_rem1 = hdtg_pkg::mod_step(n_rem1, i_ch[i], i_cnt);
        end
    end

    // lower four bits
    always_comb begin
        n_rem2 = r_rem1;
        for (int i = 3; i >= 0; i--) begin
            n_rem2 = hdtg_pkg::mod_step(n_rem2, r_chlo1[i], i_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem1  <= n_rem1;
        r_chlo1 <= i_ch[3:0];
        r_px1   <= i_px;
        r_py1   <= i_py;
        r_px2   <= r_px1;
        r_py2   <= r_py1;
        r_chw2  <= (i_cnt == 8'd0) ? 8'd0 : n_rem2;
    end

    always_comb begin
        o_item.vld = r_vld2;
        o_item.px  = r_px2;
        o_item.py  = r_py2;
        o_item.chw = r_chw2;
    end

endmodule

@@ hw/rtl/hdtg_seed.sv @@
// five-stage seed hash and tile offset derivation
module hdtg_seed (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hdtg_pkg::t_chan_item  i_item,
    input  logic [31:0]           i_seq,
    input  logic [7:0]            i_cnt,
    output hdtg_pkg::t_seed_item  o_item
);

    logic [4:0]  r_vld;
    logic [31:0] r_cfg_mix;
    logic [31:0] r_h0;
    logic [31:0] r_h1;
    logic [31:0] r_h2;
    logic [31:0] r_seed6;
    logic [5:0]  r_ax;
    logic [5:0]  r_ay;
    logic [5:0]  r_px [4];
    logic [5:0]  r_py [4];
    logic [5:0]  r_px5;
    logic [5:0]  r_py5;
    logic [31:0] r_seed5;
    logic [5:0]  r_offx5;
    logic [5:0]  r_offy5;
    logic [31:0] n_s0;
    logic [31:0] n_seed;
    logic [31:0] n_phase;
    logic [31:0] n_phase7;

    assign n_s0     = r_cfg_mix ^ ((32'(i_item.chw) + 32'd1) * hdtg_pkg::K_CHAN);
    assign n_seed   = hdtg_pkg::xs16(r_h2);
    assign n_phase  = n_seed ^ hdtg_pkg::K_GOLD;
    assign n_phase7 = r_seed6 ^ hdtg_pkg::K_GOLD;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_item.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        // the user must change configuration only while idle; the block itself does not enforce it
        r_cfg_mix <= (i_seq * hdtg_pkg::K_GOLD)
                   ^ ((32'(i_cnt) + 32'd1) * hdtg_pkg::K_DEPTH);
        r_h0      <= hdtg_pkg::xs16(n_s0);
        r_h1      <= r_h0 * hdtg_pkg::K_MIX_A;
        r_h2      <= hdtg_pkg::xs15(r_h1) * hdtg_pkg::K_MIX_B;
        r_seed6   <= n_seed;
        r_ax      <= hdtg_pkg::perm6_head(i_seq[5:0] + hdtg_pkg::K_OFFX[5:0], n_phase[5:0]);
        r_ay      <= hdtg_pkg::perm6_head(i_seq[5:0] ^ hdtg_pkg::K_OFFY[5:0],
                                          n_phase[12:7]);
        r_px[0]   <= i_item.px;
        r_py[0]   <= i_item.py;
        for (int i = 1; i < 4; i++) begin
            r_px[i] <= r_px[i-1];
            r_py[i] <= r_py[i-1];
        end
        r_px5   <= r_px[3];
        r_py5   <= r_py[3];
        r_seed5 <= r_seed6;
        r_offx5 <= hdtg_pkg::perm6_tail(r_ax, n_phase7[14:9]);
        r_offy5 <= hdtg_pkg::perm6_tail(r_ay, n_phase7[21:16]);
    end

    always_comb begin
        o_item.vld  = r_vld[4];
        o_item.px   = r_px5;
        o_item.py   = r_py5;
        o_item.seed = r_seed5;
        o_item.offx = r_offx5;
        o_item.offy = r_offy5;
    end

endmodule

@@ hw/rtl/hdtg_rank.sv @@
// five-stage rank path: coordinate permutation, interleave, rank permutation, jitter, scaling
module hdtg_rank (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hdtg_pkg::t_seed_item  i_item,
    output logic                  o_strobe,
    output logic [15:0]           o_threshold
);

    logic [4:0]  r_vld;
    logic [31:0] r_seed8;
    logic [31:0] r_seed9;
    logic [5:0]  r_hx;
    logic [5:0]  r_hy;
    logic [31:0] r_jm;
    logic [11:0] r_rank9;
    logic [31:0] r_jh1;
    logic [11:0] r_ra;
    logic [11:0] r_krhi;
    logic [31:0] r_jh2;
    logic [11:0] r_rank11;
    logic [15:0] r_thr;
    logic [5:0]  n_sx;
    logic [5:0]  n_sy;
    logic [31:0] n_kx_in;
    logic [31:0] n_ky_in;
    logic [31:0] n_kx;
    logic [31:0] n_ky;
    logic [5:0]  n_fx;
    logic [5:0]  n_fy;
    logic [31:0] n_kr;
    logic [31:0] n_jit;
    logic [27:0] n_scaled;

    assign n_sx    = i_item.px + i_item.offx;
    assign n_sy    = i_item.py + i_item.offy;
    assign n_kx_in = i_item.seed ^ hdtg_pkg::K_COORD ^ hdtg_pkg::K_KEYX;
    assign n_ky_in = i_item.seed ^ hdtg_pkg::K_COORD ^ hdtg_pkg::K_KEYY;
    assign n_kx    = r_seed8 ^ hdtg_pkg::K_COORD ^ hdtg_pkg::K_KEYX;
    assign n_ky    = r_seed8 ^ hdtg_pkg::K_COORD ^ hdtg_pkg::K_KEYY;
    assign n_fx    = hdtg_pkg::perm6_tail(r_hx, n_kx[14:9]);
    assign n_fy    = hdtg_pkg::perm6_tail(r_hy, n_ky[14:9]);
    assign n_kr    = r_seed9 ^ hdtg_pkg::K_RANK;
    assign n_jit   = hdtg_pkg::xs16(r_jh2);
    assign n_scaled = 28'(r_rank11) * 28'(hdtg_pkg::SCALE_MUL) + 28'(hdtg_pkg::SCALE_RND);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_item.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_seed8  <= i_item.seed;
        r_hx     <= hdtg_pkg::perm6_head(n_sx, n_kx_in[5:0]);
        r_hy     <= hdtg_pkg::perm6_head(n_sy, n_ky_in[5:0]);
        r_jm     <= i_item.seed ^ (32'(n_sx) * hdtg_pkg::K_JITX)
                  ^ (32'(n_sy) * hdtg_pkg::K_JITY);
        r_seed9  <= r_seed8;
        r_rank9  <= hdtg_pkg::spread6(n_fx) | (hdtg_pkg::spread6(n_fy) << 1);
        r_jh1    <= hdtg_pkg::xs16(r_jm) * hdtg_pkg::K_MIX_A;
        r_ra     <= hdtg_pkg::perm12_head(r_rank9, n_kr[11:0]);
        r_krhi   <= n_kr[20:9];
        r_jh2    <= hdtg_pkg::xs15(r_jh1) * hdtg_pkg::K_MIX_B;
        r_rank11 <= hdtg_pkg::perm12_tail(r_ra, r_krhi) + {6'd0, n_jit[5:0]};
        r_thr    <= n_scaled[27:12];
    end

    assign o_strobe    = r_vld[4];
    assign o_threshold = r_thr;

endmodule

@@ hw/rtl/hashed_dither_threshold_generator_top.sv @@
// top level of the hashed dither threshold generator
// Usage:
//   Command channel: present i_pixel_x, i_pixel_y and i_channel_index with start
//   high; a transfer happens at every rising edge with start high and busy low.
//   busy is never raised, so one transfer can be made in every cycle.
//   Result channel: o_strobe is high for exactly one cycle with o_threshold
//   valid; results come out in command order, one per command.
//   Pipeline: the result passes through twelve register stages (channel wrap 2,
//   seed hash 5, rank path 5).
//   Throughput: one threshold per cycle.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0 frame sequence, 1 channel count, low 8 bits); write only while no
//   command is in flight.
//   Reset: synchronous, active low; clears the pipeline valid bits and sets
//   both configuration registers to zero.
//   The receiver cannot stall; results must be taken on the strobe cycle.
module hashed_dither_threshold_generator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_pixel_x,
    input  logic [15:0] i_pixel_y,
    input  logic [7:0]  i_channel_index,
    output logic        o_strobe,
    output logic [15:0] o_threshold,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    logic [31:0] r_frame_seq;
    logic [7:0]  r_chan_cnt;

    hdtg_pkg::t_chan_item chan_item;
    hdtg_pkg::t_seed_item seed_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_seq <= '0;
            r_chan_cnt  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hdtg_pkg::CFG_FRAME_SEQ:  r_frame_seq <= i_cfg_data;
                hdtg_pkg::CFG_CHAN_COUNT: r_chan_cnt  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    hdtg_chan_wrap u_chan_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start),
        .i_px    (i_pixel_x[5:0]),
        .i_py    (i_pixel_y[5:0]),
        .i_ch    (i_channel_index),
        .i_cnt   (r_chan_cnt),
        .o_item  (chan_item)
    );

    hdtg_seed u_seed (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (chan_item),
        .i_seq   (r_frame_seq),
        .i_cnt   (r_chan_cnt),
        .o_item  (seed_item)
    );

    hdtg_rank u_rank (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (seed_item),
        .o_strobe    (o_strobe),
        .o_threshold (o_threshold)
    );

endmodule
